### src/i2a_pkg.sv
// Package for the integer to ASCII formatter: field widths, conversion codes,
// character constants and the command and status bundles between controller and datapath.
// Depends on nothing; imported by every other file of the block.
package i2a_pkg;

  localparam int ValueW = 64;
  localparam int CountW = 31;
  localparam int MindW  = 4;
  localparam int CharW  = 8;
  localparam int OpW    = 2;
  localparam int InDataW  = 104;
  localparam int OutDataW = 40;

  localparam logic [OpW-1:0] OP_DEC  = 2'd0;
  localparam logic [OpW-1:0] OP_HEXL = 2'd1;
  localparam logic [OpW-1:0] OP_HEXU = 2'd2;
  localparam logic [OpW-1:0] OP_PTR  = 2'd3;

  localparam logic [CountW-1:0] CNT_MAX = 31'h7fff_ffff;

  localparam logic [CharW-1:0] CH_ZERO  = 8'd48;
  localparam logic [CharW-1:0] CH_LA    = 8'd97;
  localparam logic [CharW-1:0] CH_UA    = 8'd65;
  localparam logic [CharW-1:0] CH_X_LO  = 8'd120;
  localparam logic [CharW-1:0] CH_X_UP  = 8'd88;
  localparam logic [CharW-1:0] CH_MINUS = 8'd45;
  localparam logic [CharW-1:0] CH_PLUS  = 8'd43;
  localparam logic [CharW-1:0] CH_SPACE = 8'd32;
  // "(nil)" packed with the first character in the lowest byte.
  localparam logic [5*CharW-1:0] NIL_TEXT = {8'd41, 8'd108, 8'd105, 8'd110, 8'd40};

  typedef struct packed {
    logic load;
    logic dab_step;
    logic skip_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic dab_last;
    logic skip_more;
    logic emit_last;
    logic out_free;
  } sts_t;

  // ASCII for one hex digit, in upper or lower case.
  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [CharW-1:0] base;
    base = upper ? CH_UA : CH_LA;
    if (nib < 4'd10) begin
      return CH_ZERO + {4'd0, nib};
    end else begin
      return base + {4'd0, nib} - 8'd10;
    end
  endfunction

endpackage

### src/integer_to_ascii_formatter.sv
// Top level of the integer to ASCII formatter.
// Depends on i2a_pkg, i2a_ctrl and i2a_dpath.

// The block takes one printf-style integer conversion per input word and
// returns its characters, one output word per character, with tlast on the
// final one and a saturating running count alongside. An item is taken only
// while the block is idle, so one conversion is worked at a time; the output
// register lets the next item enter while the last character still waits.
// Per item: the accept, then for signed decimal the bit-serial binary-to-BCD
// shift of the 32-bit magnitude, then the drop of leading zeros (up to 9 for
// decimal, up to 15 for hex), a step to leave the zero search, and the
// characters (1 to 18), each sent once the output register is free. The
// character rate is set by the single output register: one per cycle while
// the output is not stalled.
module integer_to_ascii_formatter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: value[63:0], plus_flag[64], space_flag[65], hash_flag[66],
  //        min_digits[70:67], base_count[101:71], zero fill [103:102]
  input  logic [i2a_pkg::InDataW-1:0]     s_axis_tdata,
  // tuser: op[1:0] (0 signed decimal, 1 hex lower, 2 hex upper, 3 pointer)
  input  logic [i2a_pkg::OpW-1:0]         s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: char_code[7:0], total_count[38:8], zero fill [39]
  output logic [i2a_pkg::OutDataW-1:0]    m_axis_tdata,
  // tlast: last character of the conversion
  output logic                            m_axis_tlast
);
  import i2a_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [CharW-1:0]  out_char;
  logic [CountW-1:0] out_cnt;

  i2a_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .in_op         (s_axis_tuser),
    .sts           (sts),
    .cmd           (cmd)
  );

  i2a_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_op     (s_axis_tuser),
    .in_value  (s_axis_tdata[63:0]),
    .in_plus   (s_axis_tdata[64]),
    .in_space  (s_axis_tdata[65]),
    .in_hash   (s_axis_tdata[66]),
    .in_mind   (s_axis_tdata[70:67]),
    .in_base   (s_axis_tdata[101:71]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_char  (out_char),
    .out_last  (m_axis_tlast),
    .out_cnt   (out_cnt)
  );

  // Pack the result word: character in the low byte, count above it.
  assign m_axis_tdata = {1'b0, out_cnt, out_char};

endmodule

### src/i2a_ctrl.sv
// Controller state machine of the integer to ASCII formatter.
// Depends on i2a_pkg; drives commands into i2a_dpath and reads its status.
module i2a_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [i2a_pkg::OpW-1:0] in_op,
  input  i2a_pkg::sts_t         sts,
  output i2a_pkg::cmd_t         cmd
);
  import i2a_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DABBLE = 2'd1;
  localparam logic [1:0] ST_SKIP   = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          state_next = (in_op == OP_DEC) ? ST_DABBLE : ST_SKIP;
        end
      end
      ST_DABBLE: begin
        cmd.dab_step = 1'b1;
        if (sts.dab_last) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (sts.skip_more) begin
          cmd.skip_step = 1'b1;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_dec_goes_bcd: assert property (@(posedge clk) disable iff (rst)
    (accept && in_op == OP_DEC) |=> state == ST_DABBLE)
    else $error("decimal item did not start the BCD conversion");

  a_dabble_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DABBLE && !sts.dab_last) |=> state == ST_DABBLE)
    else $error("BCD conversion left early");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && sts.emit_last) |=> state == ST_IDLE)
    else $error("controller did not return to idle after the last character");

endmodule

### src/i2a_dpath.sv
// Datapath of the integer to ASCII formatter: prefix and digit shift registers,
// binary to BCD converter, running count and the output register.
// Depends on i2a_pkg; controlled by i2a_ctrl.
module i2a_dpath (
  input  logic                       clk,
  input  logic                       rst,
  input  i2a_pkg::cmd_t              cmd,
  output i2a_pkg::sts_t              sts,
  input  logic [i2a_pkg::OpW-1:0]    in_op,
  input  logic [i2a_pkg::ValueW-1:0] in_value,
  input  logic                       in_plus,
  input  logic                       in_space,
  input  logic                       in_hash,
  input  logic [i2a_pkg::MindW-1:0]  in_mind,
  input  logic [i2a_pkg::CountW-1:0] in_base,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [i2a_pkg::CharW-1:0]  out_char,
  output logic                       out_last,
  output logic [i2a_pkg::CountW-1:0] out_cnt
);
  import i2a_pkg::*;

  // Working registers of one conversion.
  logic [ValueW-1:0]  dig;       // digits, most significant nibble on top
  logic [31:0]        bin;       // decimal magnitude, shifted out MSB first
  logic [4:0]         nd;        // digits still to print
  logic [4:0]         step;      // BCD shift counter
  logic [5*CharW-1:0] pre;       // prefix characters, next one in the low byte
  logic [2:0]         plen;      // prefix characters still to print
  logic [MindW-1:0]   mind;      // minimum digit count, clamped to 1..10
  logic               upper;
  logic [CountW-1:0]  cnt;

  logic [31:0]        low;
  logic               neg;
  logic [31:0]        mag;
  logic               nonzero;
  logic [5*CharW-1:0] pre_in;
  logic [2:0]         plen_in;
  logic [39:0]        dab;
  logic [CharW-1:0]   ch;
  logic [CountW-1:0]  cnt_inc;
  logic               from_pre;

  assign low     = in_value[31:0];
  assign neg     = low[31];
  assign mag     = neg ? (~low + 32'd1) : low;
  assign nonzero = |in_value;

  always_comb begin
    pre_in  = '0;
    plen_in = 3'd0;
    case (in_op)
      OP_DEC: begin
        if (neg) begin
          pre_in[CharW-1:0] = CH_MINUS;
          plen_in = 3'd1;
        end else if (in_plus) begin
          pre_in[CharW-1:0] = CH_PLUS;
          plen_in = 3'd1;
        end else if (in_space) begin
          pre_in[CharW-1:0] = CH_SPACE;
          plen_in = 3'd1;
        end
      end
      OP_HEXL, OP_HEXU: begin
        if (in_hash && nonzero) begin
          pre_in[2*CharW-1:0] = {(in_op == OP_HEXU) ? CH_X_UP : CH_X_LO, CH_ZERO};
          plen_in = 3'd2;
        end
      end
      OP_PTR: begin
        if (nonzero) begin
          pre_in[2*CharW-1:0] = {CH_X_LO, CH_ZERO};
          plen_in = 3'd2;
        end else begin
          pre_in  = NIL_TEXT;
          plen_in = 3'd5;
        end
      end
      default: begin
        plen_in = 3'd0;
      end
    endcase
  end

  // One double-dabble step: correct every BCD digit, then shift in one bit.
  always_comb begin
    dab = dig[ValueW-1:24];
    for (int i = 0; i < 10; i++) begin
      if (dab[4*i +: 4] >= 4'd5) begin
        dab[4*i +: 4] = dab[4*i +: 4] + 4'd3;
      end
    end
  end

  assign from_pre = (plen != 3'd0);
  assign ch       = from_pre ? pre[CharW-1:0] : hex_char(dig[ValueW-1:ValueW-4], upper);
  assign cnt_inc  = (cnt == CNT_MAX) ? cnt : cnt + 31'd1;

  assign sts.dab_last  = (step == 5'd31);
  assign sts.skip_more = (dig[ValueW-1:ValueW-4] == 4'd0) && (nd > {1'b0, mind});
  assign sts.emit_last = from_pre ? (plen == 3'd1 && nd == 5'd0) : (nd == 5'd1);
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pre   <= pre_in;
      plen  <= plen_in;
      cnt   <= in_base;
      step  <= 5'd0;
      bin   <= mag;
      upper <= (in_op == OP_HEXU);
      if (in_op == OP_DEC) begin
        dig  <= '0;
        nd   <= 5'd10;
        if (in_mind == 4'd0) begin
          mind <= 4'd1;
        end else if (in_mind > 4'd10) begin
          mind <= 4'd10;
        end else begin
          mind <= in_mind;
        end
      end else begin
        dig  <= in_value;
        nd   <= (in_op == OP_PTR && !nonzero) ? 5'd0 : 5'd16;
        mind <= 4'd1;
      end
    end else if (cmd.dab_step) begin
      dig[ValueW-1:24] <= {dab[38:0], bin[31]};
      bin  <= {bin[30:0], 1'b0};
      step <= step + 5'd1;
    end else if (cmd.skip_step) begin
      dig <= {dig[ValueW-5:0], 4'd0};
      nd  <= nd - 5'd1;
    end else if (cmd.emit) begin
      cnt <= cnt_inc;
      if (from_pre) begin
        pre  <= {{CharW{1'b0}}, pre[5*CharW-1:CharW]};
        plen <= plen - 3'd1;
      end else begin
        dig <= {dig[ValueW-5:0], 4'd0};
        nd  <= nd - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char <= ch;
      out_last <= sts.emit_last;
      out_cnt  <= cnt_inc;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("character emitted over an unaccepted one");

  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.skip_step |-> (dig[ValueW-1:ValueW-4] == 4'd0 && nd > {1'b0, mind}))
    else $error("dropped a significant digit");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emitted character not presented");

endmodule

### bench/integer_to_ascii_formatter_tb.sv
// Testbench for integer_to_ascii_formatter: drives printf-style integer conversions
// and checks every character word against a predictor kept in this file.
// Depends on i2a_pkg and the RTL of the block; reads no files.
module integer_to_ascii_formatter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2a_pkg::*;

  // ASCII codes that the predictor emits.
  localparam logic [7:0] ASC_ZERO    = 8'h30;
  localparam logic [7:0] ASC_MINUS   = 8'h2d;
  localparam logic [7:0] ASC_PLUS    = 8'h2b;
  localparam logic [7:0] ASC_SPACE   = 8'h20;
  localparam logic [7:0] ASC_LOWER_A = 8'h61;
  localparam logic [7:0] ASC_UPPER_A = 8'h41;
  localparam logic [7:0] ASC_X_LO    = 8'h78;
  localparam logic [7:0] ASC_X_UP    = 8'h58;

  // The running count sticks at this value.
  localparam logic [30:0] COUNT_CEILING = 31'h7fff_ffff;

  // Mismatch lines beyond this many are counted but not printed.
  localparam int REPORT_CAP = 100;

  // How long the end of the run watches for extra words after the queue drains.
  localparam int SETTLE_CYCLES = 80;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  // One conversion request as the sender sees it.
  typedef struct {
    logic [OpW-1:0] op;
    logic [63:0]    value;
    logic           plus;
    logic           space;
    logic           hash;
    logic [3:0]     mind;
    logic [30:0]    base;
  } conv_t;

  // One character word as it should leave the block.
  typedef struct {
    logic [7:0]  code;
    logic        last;
    logic [30:0] count;
  } char_word_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [OpW-1:0]      s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  // Characters predicted but not yet seen on the output, oldest first.
  char_word_t pending_chars[$];
  int         fail_count = 0;

  // Sender idling: bursts of back-to-back words separated by random gaps.
  bit tx_gappy = 1'b0;
  int burst_left = 0;

  // Receiver behavior. A long hold-off is requested through hold_request and
  // counted down inside the receiver process itself.
  rx_mode_t rx_mode = RX_ALWAYS;
  int       hold_request = 0;
  int       hold_left = 0;
  int       rx_phase = 0;

  integer_to_ascii_formatter dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk = ~clk;

  // Hard stop in case the block hangs. The slowest correct run is far below a
  // tenth of this.
  initial begin
    #2_000_000;
    $display("integer_to_ascii_formatter verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (fail_count < REPORT_CAP) begin
      $display("[%0t ns] mismatch: %s", $time, what);
    end
    fail_count++;
  endtask

  // Works out the characters of one conversion and queues them with their
  // tlast flag and running count.
  function automatic void predict_conversion(input conv_t c);
    logic [7:0]  text[$];
    logic [7:0]  digits[$];
    logic [31:0] low;
    logic [31:0] mag;
    logic [30:0] cnt;
    logic [7:0]  alpha;
    logic [3:0]  nib;
    string       nil_word;
    int          width;
    int          top;
    char_word_t  w;
    nil_word = "(nil)";
    if (c.op == OP_DEC) begin
      // Signed decimal reads only the low 32 bits as two's complement. The
      // most negative value negates to itself, which is the right magnitude
      // when read as unsigned.
      low = c.value[31:0];
      if (low[31]) begin
        mag = ~low + 32'd1;
        text.push_back(ASC_MINUS);
      end else begin
        mag = low;
        if (c.plus) begin
          text.push_back(ASC_PLUS);
        end else if (c.space) begin
          text.push_back(ASC_SPACE);
        end
      end
      // A digit count of zero acts as one; anything above ten acts as ten.
      width = (c.mind == 4'd0) ? 1 : (c.mind > 4'd10) ? 10 : int'(c.mind);
      do begin
        digits.push_front(ASC_ZERO + 8'(mag % 32'd10));
        mag = mag / 32'd10;
      end while (mag != 32'd0 || digits.size() < width);
      text = {text, digits};
    end else if (c.op == OP_PTR && c.value == 64'd0) begin
      for (int i = 0; i < nil_word.len(); i++) begin
        text.push_back(nil_word[i]);
      end
    end else begin
      // Hex in either case, or a nonzero pointer which always has the prefix.
      alpha = (c.op == OP_HEXU) ? ASC_UPPER_A : ASC_LOWER_A;
      if (c.op == OP_PTR || (c.hash && c.value != 64'd0)) begin
        text.push_back(ASC_ZERO);
        text.push_back((c.op == OP_HEXU) ? ASC_X_UP : ASC_X_LO);
      end
      top = 15;
      while (top > 0 && c.value[4*top +: 4] == 4'h0) begin
        top--;
      end
      for (int k = top; k >= 0; k--) begin
        nib = c.value[4*k +: 4];
        text.push_back((nib < 4'd10) ? ASC_ZERO + 8'(nib) : alpha + 8'(nib) - 8'd10);
      end
    end
    cnt = c.base;
    foreach (text[i]) begin
      if (cnt != COUNT_CEILING) begin
        cnt++;
      end
      w.code = text[i];
      w.last = (i == text.size() - 1);
      w.count = cnt;
      pending_chars.push_back(w);
    end
  endfunction

  // Offers one conversion and holds it until the block takes it. The valid
  // line is left high when the next word follows at once, so it is never
  // lowered and raised in the same step.
  task automatic send_conversion(input logic [OpW-1:0] op, input logic [63:0] value,
                                 input logic plus, input logic space, input logic hash,
                                 input logic [3:0] mind, input logic [30:0] base);
    conv_t c;
    c.op = op;
    c.value = value;
    c.plus = plus;
    c.space = space;
    c.hash = hash;
    c.mind = mind;
    c.base = base;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, base, mind, hash, space, plus, value};
    do @(posedge clk); while (!s_axis_tready);
    predict_conversion(c);
    if (tx_gappy) begin
      if (burst_left == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(0, 6);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Drops valid and waits until every predicted character has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_chars.size() != 0);
  endtask

  task automatic check_char_word();
    char_word_t  want;
    logic [7:0]  code;
    logic [30:0] count;
    code = m_axis_tdata[7:0];
    count = m_axis_tdata[38:8];
    if (pending_chars.size() == 0) begin
      report_mismatch($sformatf("unexpected word code=%h last=%b count=%h",
                                code, m_axis_tlast, count));
      return;
    end
    want = pending_chars.pop_front();
    if (code !== want.code) begin
      report_mismatch($sformatf("char_code %h, want %h", code, want.code));
    end
    if (m_axis_tlast !== want.last) begin
      report_mismatch($sformatf("tlast %b, want %b (char %h)", m_axis_tlast, want.last,
                                want.code));
    end
    if (count !== want.count) begin
      report_mismatch($sformatf("total_count %h, want %h", count, want.count));
    end
  endtask

  // Receiver: checks each accepted word and chooses tready for the next edge.
  // All reads here see the values from before the edge.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_char_word();
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      rx_phase = (rx_phase + 1) % 11;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:  m_axis_tready <= 1'b1;
          RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 2) != 0);
          RX_PATTERN: m_axis_tready <= (rx_phase < 6) || (rx_phase == 8);
          default:    m_axis_tready <= 1'b1;
        endcase
      end
    end
  end

  // Signs, flags, padding and the decimal corner values. The upper 32 bits
  // must be ignored, so some words carry junk there.
  task automatic test_decimal_directed();
    send_conversion(OP_DEC, 64'd0, 1'b0, 1'b0, 1'b0, 4'd1, 31'd0);
    send_conversion(OP_DEC, 64'd0, 1'b0, 1'b0, 1'b0, 4'd10, 31'd7);
    send_conversion(OP_DEC, 64'd1, 1'b1, 1'b0, 1'b0, 4'd1, 31'd100);
    send_conversion(OP_DEC, 64'd1, 1'b0, 1'b1, 1'b0, 4'd3, 31'd0);
    send_conversion(OP_DEC, 64'd5, 1'b1, 1'b1, 1'b1, 4'd1, 31'd0);
    send_conversion(OP_DEC, 64'h0000_0000_7fff_ffff, 1'b1, 1'b0, 1'b0, 4'd1, 31'd0);
    send_conversion(OP_DEC, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b0, 1'b0, 4'd1, 31'd0);
    // Most negative value, with flags that must be ignored for negatives.
    send_conversion(OP_DEC, 64'h0000_0000_8000_0000, 1'b1, 1'b1, 1'b0, 4'd1, 31'd0);
    send_conversion(OP_DEC, 64'hdead_beef_0000_007b, 1'b0, 1'b1, 1'b0, 4'd5, 31'd0);
    // Digit counts outside 1..10 clamp.
    send_conversion(OP_DEC, 64'd42, 1'b0, 1'b0, 1'b0, 4'd0, 31'd0);
    send_conversion(OP_DEC, 64'd42, 1'b0, 1'b0, 1'b0, 4'd11, 31'd0);
    send_conversion(OP_DEC, 64'hffff_ffff_ffff_fffe, 1'b0, 1'b0, 1'b0, 4'd15, 31'd0);
  endtask

  // Hex zero never gets a prefix; the prefix case follows the conversion.
  task automatic test_hex_directed();
    send_conversion(OP_HEXL, 64'd0, 1'b0, 1'b0, 1'b1, 4'd1, 31'd0);
    send_conversion(OP_HEXU, 64'd0, 1'b0, 1'b0, 1'b0, 4'd1, 31'd0);
    send_conversion(OP_HEXL, 64'h0123_4567_89ab_cdef, 1'b0, 1'b0, 1'b1, 4'd1, 31'd0);
    send_conversion(OP_HEXU, 64'hfedc_ba98_7654_3210, 1'b1, 1'b1, 1'b1, 4'd9, 31'd0);
    send_conversion(OP_HEXU, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b0, 1'b0, 4'd1, 31'd3);
    send_conversion(OP_HEXL, 64'h1, 1'b0, 1'b0, 1'b1, 4'd1, 31'd0);
  endtask

  task automatic test_pointer_directed();
    send_conversion(OP_PTR, 64'd0, 1'b0, 1'b0, 1'b1, 4'd1, 31'd0);
    send_conversion(OP_PTR, 64'h1a, 1'b0, 1'b0, 1'b0, 4'd1, 31'd0);
    send_conversion(OP_PTR, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 1'b0, 4'd1, 31'd0);
  endtask

  // The running count must stop at its ceiling, also partway through a word.
  task automatic test_count_saturation();
    send_conversion(OP_DEC, 64'h8000_0000, 1'b0, 1'b0, 1'b0, 4'd10, 31'h7fff_fff5);
    send_conversion(OP_PTR, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b0, 1'b0, 4'd1,
                    31'h7fff_ffff);
    send_conversion(OP_HEXL, 64'd0, 1'b0, 1'b0, 1'b0, 4'd1, 31'h7fff_fffe);
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering long conversions, so the block fills and stalls its input.
  task automatic test_output_backpressure();
    wait_drained();
    rx_mode = RX_ALWAYS;
    tx_gappy = 1'b0;
    hold_request = 300;
    repeat (5) begin
      send_conversion(OP_DEC, 64'h8000_0000, 1'b0, 1'b0, 1'b0, 4'd10, 31'($urandom));
      send_conversion(OP_PTR, {$urandom, $urandom} | 64'h1, 1'b0, 1'b0, 1'b0, 4'd1,
                      31'($urandom));
    end
    wait_drained();
  endtask

  // Random conversions in phases of different sender and receiver behavior.
  // Values lean toward the interesting classes: zero, negatives, powers of
  // ten, single nibbles and the extremes.
  task automatic test_random_conversions();
    logic [63:0]    value;
    logic [OpW-1:0] op;
    logic [3:0]     mind;
    logic [30:0]    base;
    int             k;
    for (int phase = 0; phase < 6; phase++) begin
      tx_gappy = (phase % 3) != 0;
      rx_mode = rx_mode_t'(phase % 3);
      // Half the phases start from a fully drained block.
      if (phase % 2 == 1) begin
        wait_drained();
      end
      repeat (50) begin
        case ($urandom_range(0, 7))
          0: value = {$urandom, $urandom};
          1: value = 64'd0;
          2: value = {$urandom, 1'b1, 31'($urandom)};
          3: value = {32'($urandom_range(0, 1) ? $urandom : 0), 32'($urandom_range(0, 999))};
          4: begin
            k = $urandom_range(0, 9);
            value = {$urandom, 32'(10 ** k - 1 + $urandom_range(0, 2))};
          end
          5: value = 64'($urandom_range(1, 15)) << (4 * $urandom_range(0, 15));
          6: value = $urandom_range(0, 1) ? {$urandom, 32'h8000_0000} : '1;
          default: value = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        op = ($urandom_range(0, 9) < 4) ? OP_DEC : OpW'($urandom_range(0, 3));
        mind = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(1, 10)) :
               4'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
          0:       base = COUNT_CEILING - 31'($urandom_range(0, 20));
          1:       base = 31'($urandom_range(0, 100));
          default: base = 31'($urandom);
        endcase
        send_conversion(op, value, 1'($urandom), 1'($urandom), 1'($urandom), mind, base);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_decimal_directed();
    test_hex_directed();
    test_pointer_directed();
    test_count_saturation();
    test_output_backpressure();
    test_random_conversions();
    // Let every predicted character arrive, then watch a while longer for
    // anything extra.
    wait_drained();
    rx_mode = RX_ALWAYS;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("integer_to_ascii_formatter verification clean");
    end else begin
      $display("integer_to_ascii_formatter verification failed");
    end
    $finish;
  end

endmodule
